FILE: hdl/date_time_second_increment_unit_macros.svh
// Assertion macros shared by the date and time increment design
`ifndef DATE_TIME_SECOND_INCREMENT_UNIT_MACROS_SVH
`define DATE_TIME_SECOND_INCREMENT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset
`define DTSI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset
`define DTSI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dtsi_pkg.sv
// Types, limits and month length lookup for the date and time increment unit
package dtsi_pkg;

    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned YearW   = 14;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned SecondW = 6;
    localparam int unsigned DataW   = 40;
    localparam int unsigned UserW   = 1;

    localparam logic [MonthW-1:0]  MonthFirst = 4'd1;
    localparam logic [MonthW-1:0]  MonthLast  = 4'd12;
    localparam logic [MonthW-1:0]  MonthFeb   = 4'd2;
    localparam logic [DayW-1:0]    DayFirst   = 5'd1;
    localparam logic [YearW-1:0]   YearLast   = 14'd9999;
    localparam logic [HourW-1:0]   HourLast   = 5'd23;
    localparam logic [MinuteW-1:0] MinuteLast = 6'd59;
    localparam logic [SecondW-1:0] SecondLast = 6'd59;

    // floor(y / 100) = (y * Div100Mul) >> Div100Shift for every 14-bit y
    localparam int unsigned QuotW       = 8;
    localparam int unsigned Div100Shift = 19;
    localparam logic [12:0] Div100Mul   = 13'd5243;
    localparam logic [6:0]  Century     = 7'd100;

    typedef struct packed {
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [YearW-1:0]   year;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
    } dt_fields_t;

    typedef struct packed {
        logic bad;
        logic sec_wrap;
        logic min_wrap;
        logic hour_wrap;
        logic day_last;
        logic dec;
        logic year_last;
    } dt_carry_t;

    function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                     input logic leap);
        logic [DayW-1:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MonthFeb:                len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: hdl/date_time_second_increment_unit.sv
// Throughput: one item per cycle; three register stages, each advancing when it is
// empty or the stage after it moves, so a stall at the output loses nothing.
// Stage one divides the year by 100, stage two decides range and carries, stage three
// builds the result. Reset (rst_n low, asynchronous) empties all stages.
module date_time_second_increment_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // month[3:0] day[8:4] year[22:9] hour[27:23] minute[33:28] second[39:34]
    input  logic [dtsi_pkg::DataW-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // month[3:0] day[8:4] year[22:9] hour[27:23] minute[33:28] second[39:34]
    output logic [dtsi_pkg::DataW-1:0]  m_axis_tdata,
    // bad_input[0]
    output logic [dtsi_pkg::UserW-1:0]  m_axis_tuser
);
    import dtsi_pkg::*;
    `include "date_time_second_increment_unit_macros.svh"

    // Stage advance enables
    logic adv1, adv2, adv3;

    logic         v1_reg, v2_reg, v3_reg;
    dt_fields_t   s1_reg, s2_reg;
    logic [QuotW-1:0] q1_reg;
    logic         basic_bad1_reg;
    dt_carry_t    c2_reg;
    logic [DataW-1:0] out_data_reg;
    logic             out_bad_reg;

    dt_fields_t   in_fields;
    logic [YearW+12:0] q_prod;
    logic [QuotW-1:0]  q1_next;
    logic         basic_bad1_next;

    logic [YearW-1:0] rem2;
    logic         leap2;
    logic [DayW-1:0]  mlen2;
    dt_carry_t    c2_next;

    dt_fields_t   o3;
    logic [DataW-1:0] out_data_next;

    assign adv3 = !v3_reg || m_axis_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    // Stage one: unpack, coarse range checks, reciprocal multiply for year / 100
    always_comb
    begin
        in_fields.month  = s_axis_tdata[3:0];
        in_fields.day    = s_axis_tdata[8:4];
        in_fields.year   = s_axis_tdata[22:9];
        in_fields.hour   = s_axis_tdata[27:23];
        in_fields.minute = s_axis_tdata[33:28];
        in_fields.second = s_axis_tdata[39:34];
        q_prod  = (YearW+13)'(in_fields.year) * (YearW+13)'(Div100Mul);
        q1_next = q_prod[Div100Shift +: QuotW];
        basic_bad1_next = (in_fields.month < MonthFirst) || (in_fields.month > MonthLast) ||
                          (in_fields.year > YearLast) || (in_fields.hour > HourLast) ||
                          (in_fields.minute > MinuteLast) || (in_fields.second > SecondLast);
    end

    // Stage two: leap rule, month length, day check and carry flags
    always_comb
    begin
        rem2  = s1_reg.year - (YearW'(q1_reg) * YearW'(Century));
        leap2 = ((s1_reg.year[1:0] == 2'd0) && (rem2 != '0)) ||
                ((rem2 == '0) && (q1_reg[1:0] == 2'd0));
        mlen2 = month_length(s1_reg.month, leap2);
        c2_next.bad       = basic_bad1_reg || (s1_reg.day < DayFirst) || (s1_reg.day > mlen2);
        c2_next.sec_wrap  = (s1_reg.second == SecondLast);
        c2_next.min_wrap  = (s1_reg.minute == MinuteLast);
        c2_next.hour_wrap = (s1_reg.hour == HourLast);
        c2_next.day_last  = (s1_reg.day == mlen2);
        c2_next.dec       = (s1_reg.month == MonthLast);
        c2_next.year_last = (s1_reg.year == YearLast);
    end

    // Stage three: apply the carries, zero the data word on bad input
    always_comb
    begin
        o3 = s2_reg;
        if (c2_reg.sec_wrap)
        begin
            o3.second = '0;
            if (c2_reg.min_wrap)
            begin
                o3.minute = '0;
                if (c2_reg.hour_wrap)
                begin
                    o3.hour = '0;
                    if (!c2_reg.day_last)
                    begin
                        o3.day = s2_reg.day + DayW'(1);
                    end
                    else
                    begin
                        o3.day = DayFirst;
                        if (c2_reg.dec)
                        begin
                            o3.month = MonthFirst;
                            o3.year  = c2_reg.year_last ? '0 : s2_reg.year + YearW'(1);
                        end
                        else
                        begin
                            o3.month = s2_reg.month + MonthW'(1);
                        end
                    end
                end
                else
                begin
                    o3.hour = s2_reg.hour + HourW'(1);
                end
            end
            else
            begin
                o3.minute = s2_reg.minute + MinuteW'(1);
            end
        end
        else
        begin
            o3.second = s2_reg.second + SecondW'(1);
        end
        if (c2_reg.bad)
        begin
            out_data_next = '0;
        end
        else
        begin
            out_data_next = {o3.second, o3.minute, o3.hour, o3.year, o3.day, o3.month};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload: hold while the stage waits
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg         <= in_fields;
            q1_reg         <= q1_next;
            basic_bad1_reg <= basic_bad1_next;
        end
        if (adv2)
        begin
            s2_reg <= s1_reg;
            c2_reg <= c2_next;
        end
        if (adv3)
        begin
            out_data_reg <= out_data_next;
            out_bad_reg  <= c2_reg.bad;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_bad_reg;

    `DTSI_ASSERT_IMP(a_bad_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0,
        "bad input transfer carries non-zero data")
    `DTSI_ASSERT_IMP(a_sec_range, m_axis_tvalid, m_axis_tdata[39:34] <= SecondLast,
        "second out of range on output")
    `DTSI_ASSERT_IMP(a_full_stall, !s_axis_tready, v1_reg && v2_reg && v3_reg,
        "input stalled while a stage is empty")
    `DTSI_ASSERT_NXT(a_mid_hold, v2_reg && v3_reg && !m_axis_tready, v2_reg,
        "stage two item dropped during output stall")

endmodule

FILE: tb/sv/tb.sv
// Self-checking stream testbench for the one-second date and time increment unit
module tb;

    import dtsi_pkg::*;

    localparam int unsigned RandomItems = 1700;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 12;
    localparam int unsigned PlanRows    = 24;

    typedef struct packed {
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [YearW-1:0]   year;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
        logic               bad;
    } dt_result_t;

    // typed: want holds the result as read off by hand, otherwise the predictor decides
    typedef struct packed {
        logic       typed;
        dt_fields_t stim;
        dt_result_t want;
    } plan_row_t;

    localparam dt_result_t Flagged = '{bad: 1'b1, default: '0};

    localparam plan_row_t Plan [PlanRows] = '{
        '{1'b1, '{4'd1, 5'd1, 14'd0, 5'd0, 6'd0, 6'd0},
                '{4'd1, 5'd1, 14'd0, 5'd0, 6'd0, 6'd1, 1'b0}},
        '{1'b1, '{4'd12, 5'd31, 14'd9999, 5'd23, 6'd59, 6'd59},
                '{4'd1, 5'd1, 14'd0, 5'd0, 6'd0, 6'd0, 1'b0}},
        '{1'b1, '{4'd0, 5'd1, 14'd2000, 5'd0, 6'd0, 6'd0}, Flagged},
        '{1'b1, '{4'd13, 5'd1, 14'd2000, 5'd0, 6'd0, 6'd0}, Flagged},
        '{1'b1, '{4'd15, 5'd31, 14'd16383, 5'd31, 6'd63, 6'd63}, Flagged},
        '{1'b1, '{4'd1, 5'd0, 14'd2000, 5'd0, 6'd0, 6'd0}, Flagged},
        '{1'b1, '{4'd4, 5'd31, 14'd2021, 5'd12, 6'd0, 6'd0}, Flagged},
        '{1'b1, '{4'd2, 5'd29, 14'd1900, 5'd0, 6'd0, 6'd0}, Flagged},
        '{1'b1, '{4'd1, 5'd1, 14'd10000, 5'd0, 6'd0, 6'd0}, Flagged},
        '{1'b1, '{4'd1, 5'd1, 14'd16383, 5'd0, 6'd0, 6'd0}, Flagged},
        '{1'b1, '{4'd1, 5'd1, 14'd2000, 5'd24, 6'd0, 6'd0}, Flagged},
        '{1'b1, '{4'd1, 5'd1, 14'd2000, 5'd0, 6'd60, 6'd0}, Flagged},
        '{1'b1, '{4'd1, 5'd1, 14'd2000, 5'd0, 6'd0, 6'd60}, Flagged},
        '{1'b1, '{4'd1, 5'd1, 14'd2000, 5'd0, 6'd63, 6'd0}, Flagged},
        // year zero counts as a leap year
        '{1'b0, '{4'd2, 5'd29, 14'd0, 5'd23, 6'd59, 6'd59}, '0},
        '{1'b0, '{4'd2, 5'd29, 14'd2000, 5'd23, 6'd59, 6'd59}, '0},
        '{1'b0, '{4'd2, 5'd28, 14'd2023, 5'd23, 6'd59, 6'd59}, '0},
        '{1'b0, '{4'd2, 5'd28, 14'd2024, 5'd23, 6'd59, 6'd59}, '0},
        '{1'b0, '{4'd2, 5'd28, 14'd2100, 5'd23, 6'd59, 6'd59}, '0},
        '{1'b0, '{4'd4, 5'd30, 14'd2021, 5'd23, 6'd59, 6'd59}, '0},
        '{1'b0, '{4'd1, 5'd31, 14'd1999, 5'd23, 6'd59, 6'd59}, '0},
        '{1'b0, '{4'd6, 5'd15, 14'd1234, 5'd10, 6'd59, 6'd59}, '0},
        '{1'b0, '{4'd6, 5'd15, 14'd1234, 5'd10, 6'd20, 6'd59}, '0},
        '{1'b0, '{4'd12, 5'd31, 14'd2019, 5'd23, 6'd59, 6'd59}, '0}
    };

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [DataW-1:0]    s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [DataW-1:0]    m_axis_tdata;
    logic [UserW-1:0]    m_axis_tuser;

    dt_result_t          pending_moments [$];
    dt_result_t          got;
    dt_result_t          want;
    logic                quiet;
    int unsigned         sink_stall;
    int unsigned         sink_draw;
    int unsigned         cycles;
    int unsigned         n_sent;
    int unsigned         n_results;
    int unsigned         n_flagged;
    int unsigned         n_day_carry;
    int unsigned         n_errors;

    date_time_second_increment_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        case (m)
            2:             return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // month sits in the lowest bits of the stream word, second in the highest
    function automatic logic [DataW-1:0] pack_moment(input dt_fields_t f);
        return {f.second, f.minute, f.hour, f.year, f.day, f.month};
    endfunction

    function automatic dt_result_t advance_one_second(input dt_fields_t f);
        dt_result_t  r;
        int unsigned mo;
        int unsigned dy;
        int unsigned yr;
        int unsigned hr;
        int unsigned mi;
        int unsigned se;
        r  = '0;
        mo = f.month;
        dy = f.day;
        yr = f.year;
        hr = f.hour;
        mi = f.minute;
        se = f.second;
        if (mo < 1 || mo > MonthLast || yr > YearLast || hr > HourLast ||
            mi > MinuteLast || se > SecondLast || dy < 1 || dy > days_in(mo, yr))
        begin
            r.bad = 1'b1;
            return r;
        end
        se++;
        if (se > SecondLast)
        begin
            se = 0;
            mi++;
            if (mi > MinuteLast)
            begin
                mi = 0;
                hr++;
                if (hr > HourLast)
                begin
                    hr = 0;
                    if (dy != days_in(mo, yr))
                        dy++;
                    else
                    begin
                        dy = 1;
                        if (mo == MonthLast)
                        begin
                            mo = 1;
                            yr = (yr == YearLast) ? 0 : yr + 1;
                        end
                        else
                            mo++;
                    end
                end
            end
        end
        r.month  = MonthW'(mo);
        r.day    = DayW'(dy);
        r.year   = YearW'(yr);
        r.hour   = HourW'(hr);
        r.minute = MinuteW'(mi);
        r.second = SecondW'(se);
        return r;
    endfunction

    // well-formed moment, leaning towards the last day, hour, minute and second
    function automatic dt_fields_t pick_valid_moment();
        dt_fields_t  f;
        int unsigned y;
        int unsigned m;
        int unsigned len;
        case ($urandom_range(0, 5))
            0:       y = YearLast;
            1:       y = $urandom_range(0, 99) * 100;
            2:       y = $urandom_range(0, 2499) * 4;
            default: y = $urandom_range(0, YearLast);
        endcase
        m = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
        len = days_in(m, y);
        f.year   = YearW'(y);
        f.month  = MonthW'(m);
        f.day    = DayW'(($urandom_range(0, 1) == 0) ? len : $urandom_range(1, len));
        f.hour   = HourW'(($urandom_range(0, 1) == 0) ? HourLast : $urandom_range(0, 23));
        f.minute = MinuteW'(($urandom_range(0, 4) < 3) ? MinuteLast : $urandom_range(0, 59));
        f.second = SecondW'(($urandom_range(0, 9) < 7) ? SecondLast : $urandom_range(0, 59));
        return f;
    endfunction

    task automatic flag_mismatch(input string field, input int unsigned seen,
                                 input int unsigned wanted);
        if (n_errors < 20)
            $display("mismatch on %s in result %0d: got %0d, want %0d",
                     field, n_results, seen, wanted);
        n_errors++;
    endtask

    task automatic send_moment(input dt_fields_t f, input dt_result_t expected);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_moment(f);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_moments.push_back(expected);
        n_sent++;
        if (!expected.bad && expected.day != f.day)
            n_day_carry++;
    endtask

    // sink: after each transfer, hold tready low for a freshly drawn number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_stall    <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            sink_draw = quiet ? 0 : $urandom_range(0, 8);
            sink_stall    <= sink_draw;
            m_axis_tready <= (sink_draw == 0);
        end
        else if (sink_stall != 0)
        begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= (sink_stall == 1);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            {got.second, got.minute, got.hour, got.year, got.day, got.month} = m_axis_tdata;
            got.bad = m_axis_tuser[0];
            if (got.bad)
                n_flagged++;
            if (pending_moments.size() == 0)
            begin
                if (n_errors < 20)
                    $display("unexpected result %0d with nothing outstanding", n_results);
                n_errors++;
            end
            else
            begin
                want = pending_moments.pop_front();
                if (got.month != want.month)
                    flag_mismatch("month", got.month, want.month);
                if (got.day != want.day)
                    flag_mismatch("day", got.day, want.day);
                if (got.year != want.year)
                    flag_mismatch("year", got.year, want.year);
                if (got.hour != want.hour)
                    flag_mismatch("hour", got.hour, want.hour);
                if (got.minute != want.minute)
                    flag_mismatch("minute", got.minute, want.minute);
                if (got.second != want.second)
                    flag_mismatch("second", got.second, want.second);
                if (got.bad != want.bad)
                    flag_mismatch("bad_input", got.bad, want.bad);
            end
            n_results++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_moments.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        dt_fields_t  stim;
        int unsigned len;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        cycles        = 0;
        n_sent        = 0;
        n_results     = 0;
        n_flagged     = 0;
        n_day_carry   = 0;
        n_errors      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PlanRows; i++)
            send_moment(Plan[i].stim,
                        Plan[i].typed ? Plan[i].want : advance_one_second(Plan[i].stim));

        for (int i = 0; i < RandomItems; i++)
        begin
            // every fourth stretch of fifty items runs with no idling on either side
            quiet = ((i % 200) >= 150);
            case ($urandom_range(0, 19)) inside
                [0:13]:
                    stim = pick_valid_moment();
                [14:16]:
                begin
                    // push exactly one field out of its range
                    stim = pick_valid_moment();
                    len  = days_in(stim.month, stim.year);
                    case ($urandom_range(0, 5))
                        0: stim.month  = ($urandom_range(0, 1) == 0) ?
                                         4'd0 : MonthW'($urandom_range(13, 15));
                        1: stim.day    = ($urandom_range(0, 1) == 0) ? 5'd0 : DayW'(len + 1);
                        2: stim.year   = YearW'($urandom_range(10000, 16383));
                        3: stim.hour   = HourW'($urandom_range(24, 31));
                        4: stim.minute = MinuteW'($urandom_range(60, 63));
                        default: stim.second = SecondW'($urandom_range(60, 63));
                    endcase
                end
                default:
                begin
                    stim.month  = MonthW'($urandom_range(0, 15));
                    stim.day    = DayW'($urandom_range(0, 31));
                    stim.year   = YearW'($urandom_range(0, 16383));
                    stim.hour   = HourW'($urandom_range(0, 31));
                    stim.minute = MinuteW'($urandom_range(0, 63));
                    stim.second = SecondW'($urandom_range(0, 63));
                end
            endcase
            send_moment(stim, advance_one_second(stim));
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        while (pending_moments.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("%0d moments sent, %0d results checked, %0d flagged out of range",
                 n_sent, n_results, n_flagged);
        $display("%0d day rollovers across month, leap and year boundaries, %0d mismatches",
                 n_day_carry, n_errors);
        if (n_errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
